FILE: src/rgb2hsl_pkg.sv
// ============================================================================
// rgb2hsl_pkg
// Shared widths, constants and the divider request bundle of the RGB to HSL
// converter.
// ============================================================================
package rgb2hsl_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int HUE_W      = 15;  // hue, 1/64 degree
  localparam int FRAC_W     = 13;  // saturation / lightness, 4096 = 1.0
  localparam int UNITS_W    = 11;  // sector*spread + channel difference, <= 1530
  localparam int HUE_NUM_W  = 24;  // 7680*units + spread
  localparam int SAT_NUM_W  = 21;  // 8192*spread + den
  localparam int LUM_NUM_W  = 22;  // 8192*sum + 510
  localparam int SPAN_DEN_W = 9;   // doubled spread or doubled saturation den
  localparam int DIV_QUO_W  = 15;  // quotient bits, one per divider stage

  // lightness divides by the constant 1020 through a reciprocal multiply:
  // floor(n / 1020) == (n * LUM_RECIP) >> LUM_SHIFT for every n < 2^22
  localparam int LUM_RECIP_W = 23;
  localparam int LUM_PROD_W  = 45;
  localparam int LUM_SHIFT   = 32;

  // cycles from an accepted start to the edge that takes the result beat
  localparam int LATENCY = 20;

  localparam logic [HUE_W-1:0]       HUE_FULL_TURN = 15'd23040;
  localparam logic [HUE_NUM_W-1:0]   HUE_NUM_SCALE = 24'd7680;  // 2 * 3840
  localparam logic [LUM_NUM_W-1:0]   LUM_NUM_BIAS  = 22'd510;
  localparam logic [LUM_RECIP_W-1:0] LUM_RECIP     = 23'd4210753;  // ceil(2^32 / 1020)

  // round(n/d) is carried as floor((2n + d) / 2d)
  typedef struct packed {
    logic [HUE_NUM_W-1:0]  hue_num;
    logic [SPAN_DEN_W-1:0] hue_den;
    logic [SAT_NUM_W-1:0]  sat_num;
    logic [SPAN_DEN_W-1:0] sat_den;
    logic [LUM_NUM_W-1:0]  lum_num;
  } div_req_t;

endpackage

FILE: src/rgb2hsl_front.sv
// ============================================================================
// rgb2hsl_front
// Four register stages: input capture, max/min and sector, spread and
// units, then the dividend/divisor pairs for the three quotients.
// ============================================================================
module rgb2hsl_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [rgb2hsl_pkg::CH_W-1:0]          red,
  input  logic [rgb2hsl_pkg::CH_W-1:0]          green,
  input  logic [rgb2hsl_pkg::CH_W-1:0]          blue,
  output logic                                  req_valid,
  output rgb2hsl_pkg::div_req_t                 req
);

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  localparam int CW = rgb2hsl_pkg::CH_W;
  localparam int UW = rgb2hsl_pkg::UNITS_W;

  // stage 1
  logic          s1_valid;
  logic [CW-1:0] s1_r, s1_g, s1_b;
  // stage 2
  logic          s2_valid;
  logic [CW-1:0] s2_r, s2_g, s2_b, s2_mx, s2_mn;
  sector_t       s2_sec;
  logic          s2_g_lt_b;
  // stage 3
  logic          s3_valid;
  logic [CW:0]   s3_sum;
  logic [CW-1:0] s3_d, s3_den;
  logic [UW-1:0] s3_units;
  logic          s3_grey;

  // stage 2 combinational
  logic [CW-1:0] mx, mn;
  sector_t       sec;
  // stage 3 combinational
  logic [CW:0]   sum;
  logic [CW-1:0] d, den;
  logic [UW-1:0] units;
  // stage 4 combinational
  rgb2hsl_pkg::div_req_t req_next;

  always_comb begin
    if (s1_r >= s1_g && s1_r >= s1_b) begin
      sec = SEC_RED;
      mx  = s1_r;
    end else if (s1_g >= s1_b) begin
      sec = SEC_GREEN;
      mx  = s1_g;
    end else begin
      sec = SEC_BLUE;
      mx  = s1_b;
    end
    mn = s1_r;
    if (s1_g < mn) mn = s1_g;
    if (s1_b < mn) mn = s1_b;
  end

  always_comb begin
    sum = {1'b0, s2_mx} + {1'b0, s2_mn};
    d   = s2_mx - s2_mn;
    if (sum > (CW+1)'(255)) begin
      den = CW'((CW+1)'(510) - sum);
    end else begin
      den = sum[CW-1:0];
    end
    // all three forms stay non-negative and below 2^UW
    case (s2_sec)
      SEC_RED: begin
        if (s2_g_lt_b) begin
          units = UW'(UW'(d) * UW'(6)) - UW'(s2_b - s2_g);
        end else begin
          units = UW'(s2_g - s2_b);
        end
      end
      SEC_GREEN: units = UW'({d, 1'b0}) + UW'(s2_b) - UW'(s2_r);
      SEC_BLUE:  units = UW'({d, 2'b0}) + UW'(s2_r) - UW'(s2_g);
      default:   units = '0;
    endcase
  end

  always_comb begin
    // grey pixel: 0/1 gives zero hue and saturation without a flag
    if (s3_grey) begin
      req_next.hue_num = '0;
      req_next.hue_den = rgb2hsl_pkg::SPAN_DEN_W'(1);
      req_next.sat_num = '0;
      req_next.sat_den = rgb2hsl_pkg::SPAN_DEN_W'(1);
    end else begin
      req_next.hue_num = rgb2hsl_pkg::HUE_NUM_W'(
          rgb2hsl_pkg::HUE_NUM_W'(s3_units) * rgb2hsl_pkg::HUE_NUM_SCALE
          + rgb2hsl_pkg::HUE_NUM_W'(s3_d));
      req_next.hue_den = {s3_d, 1'b0};
      req_next.sat_num = rgb2hsl_pkg::SAT_NUM_W'({s3_d, 13'd0})
                       + rgb2hsl_pkg::SAT_NUM_W'(s3_den);
      req_next.sat_den = {s3_den, 1'b0};
    end
    req_next.lum_num = rgb2hsl_pkg::LUM_NUM_W'({s3_sum, 13'd0})
                     + rgb2hsl_pkg::LUM_NUM_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      req_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      req_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r      <= red;
    s1_g      <= green;
    s1_b      <= blue;
    s2_r      <= s1_r;
    s2_g      <= s1_g;
    s2_b      <= s1_b;
    s2_mx     <= mx;
    s2_mn     <= mn;
    s2_sec    <= sec;
    s2_g_lt_b <= s1_g < s1_b;
    s3_sum    <= sum;
    s3_d      <= d;
    s3_den    <= den;
    s3_units  <= units;
    s3_grey   <= s2_mx == s2_mn;
    req       <= req_next;
  end

endmodule

FILE: src/rgb2hsl_div.sv
// ============================================================================
// rgb2hsl_div
// Pipelined restoring divider: one quotient bit per register stage, MSB
// first. Needs num < den * 2^QUO_W.
// ============================================================================
module rgb2hsl_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 9,
  parameter int QUO_W = 15
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  // stage outputs; the last stage keeps only its quotient
  logic [W-1:0]     rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [W-1:0]     rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [W-1:0]     trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = W'(den_in) << B;
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      quo_q[k] <= fits ? (quo_in | (QUO_W'(1) << B)) : quo_in;
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= fits ? rem_in - trial : rem_in;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

FILE: src/rgb_to_hsl_converter_core.sv
// ============================================================================
// rgb_to_hsl_converter_core
// One RGB pixel per clock in, one hue / saturation / lightness beat out,
// fully pipelined.
// ============================================================================
//
//  channel  | signals                         | handshake
//  ---------+---------------------------------+-------------------------------
//  pixel in | start, red, green, blue         | beat taken when start & !busy
//  hsl out  | done, hue, saturation, lightness| one-cycle strobe, no back-pressure
//
// Timing:
//  - A new pixel may enter every cycle; busy is held low.
//  - From the accepting edge to the edge that takes the result beat, a pixel
//    passes four front stages (capture, max/min, spread, dividend build),
//    fifteen divider stages (one quotient bit each) and one output stage.
//  - The fifteen-stage restoring dividers set the depth; each stage is one
//    ~24-bit compare and subtract. Lightness divides by a constant, so it is
//    one reciprocal multiply followed by a matching delay line.
//  - rst (synchronous) clears only the valid chain; data registers are
//    free running.
//  - The receiver cannot stall, so no stage ever holds; beats leave in order.
//
module rgb_to_hsl_converter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [rgb2hsl_pkg::CH_W-1:0]        red,
  input  logic [rgb2hsl_pkg::CH_W-1:0]        green,
  input  logic [rgb2hsl_pkg::CH_W-1:0]        blue,
  output logic                                done,
  output logic [rgb2hsl_pkg::HUE_W-1:0]       hue,
  output logic [rgb2hsl_pkg::FRAC_W-1:0]      saturation,
  output logic [rgb2hsl_pkg::FRAC_W-1:0]      lightness
);

  localparam int QW = rgb2hsl_pkg::DIV_QUO_W;

  logic                         req_valid;
  rgb2hsl_pkg::div_req_t        req;
  logic [QW-1:0]                vpipe;     // valid bits riding with divider stages
  logic [QW-1:0]                hue_q, sat_q;
  logic [rgb2hsl_pkg::HUE_W-1:0] hue_next;
  logic [rgb2hsl_pkg::LUM_PROD_W-1:0] lum_prod;
  logic [rgb2hsl_pkg::FRAC_W-1:0]     lum_dly [QW-1];
  logic [rgb2hsl_pkg::FRAC_W-1:0]     lum_q;

  // never back-pressures the source
  assign busy = 1'b0;

  rgb2hsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .req_valid (req_valid),
    .req       (req)
  );

  // hue: round(3840*units / spread), up to 23040
  rgb2hsl_div #(
    .NUM_W (rgb2hsl_pkg::HUE_NUM_W),
    .DEN_W (rgb2hsl_pkg::SPAN_DEN_W),
    .QUO_W (rgb2hsl_pkg::DIV_QUO_W)
  ) u_div_hue (
    .clk (clk),
    .num (req.hue_num),
    .den (req.hue_den),
    .quo (hue_q)
  );

  // saturation: round(4096*spread / den)
  rgb2hsl_div #(
    .NUM_W (rgb2hsl_pkg::SAT_NUM_W),
    .DEN_W (rgb2hsl_pkg::SPAN_DEN_W),
    .QUO_W (rgb2hsl_pkg::DIV_QUO_W)
  ) u_div_sat (
    .clk (clk),
    .num (req.sat_num),
    .den (req.sat_den),
    .quo (sat_q)
  );

  // lightness: round(4096*sum / 510) = floor(lum_num / 1020) by reciprocal,
  // one multiply stage then QW-1 delay stages to line up with the dividers
  always_ff @(posedge clk) begin
    lum_prod   <= rgb2hsl_pkg::LUM_PROD_W'(req.lum_num)
                * rgb2hsl_pkg::LUM_PROD_W'(rgb2hsl_pkg::LUM_RECIP);
    lum_dly[0] <= lum_prod[rgb2hsl_pkg::LUM_SHIFT +: rgb2hsl_pkg::FRAC_W];
    for (int k = 1; k < QW - 1; k++) begin
      lum_dly[k] <= lum_dly[k-1];
    end
  end

  assign lum_q = lum_dly[QW-2];

  // 360 degrees wraps to 0
  always_comb begin
    if (hue_q >= rgb2hsl_pkg::HUE_FULL_TURN) begin
      hue_next = hue_q - rgb2hsl_pkg::HUE_FULL_TURN;
    end else begin
      hue_next = hue_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[QW-2:0], req_valid};
      done  <= vpipe[QW-1];
    end
  end

  // saturation never exceeds 4096, so the top bits are zero
  always_ff @(posedge clk) begin
    hue        <= hue_next;
    saturation <= sat_q[rgb2hsl_pkg::FRAC_W-1:0];
    lightness  <= lum_q;
  end

endmodule

FILE: src/rgb2hsl_chk.sv
// ============================================================================
// rgb2hsl_chk
// Port-level checks of the converter: latency, output ranges, grey pixels.
// ============================================================================
module rgb2hsl_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [rgb2hsl_pkg::CH_W-1:0]        red,
  input logic [rgb2hsl_pkg::CH_W-1:0]        green,
  input logic [rgb2hsl_pkg::CH_W-1:0]        blue,
  input logic                                done,
  input logic [rgb2hsl_pkg::HUE_W-1:0]       hue,
  input logic [rgb2hsl_pkg::FRAC_W-1:0]      saturation,
  input logic [rgb2hsl_pkg::FRAC_W-1:0]      lightness
);

  localparam int LAT = rgb2hsl_pkg::LATENCY;

  // every accepted pixel yields a result beat a fixed time later
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted pixel produced no result beat");

  // no result beat without a pixel accepted a fixed time earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without an accepted pixel");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < rgb2hsl_pkg::HUE_FULL_TURN) && (saturation <= 13'd4096)
             && (lightness <= 13'd4096))
    else $error("result field out of range");

  // grey pixel gives zero hue and saturation
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red == green && green == blue)
      |-> ##LAT (hue == '0 && saturation == '0))
    else $error("grey pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsl_converter_core rgb2hsl_chk u_chk (.*);

FILE: sim/hsl_result_checker.sv
// ============================================================================
// hsl_result_checker
// Watches the pixel and HSL channels of the converter. It predicts each
// pixel's hue, saturation and lightness and checks the result beats in order.
// ============================================================================
module hsl_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [rgb2hsl_pkg::CH_W-1:0]   red,
  input  logic [rgb2hsl_pkg::CH_W-1:0]   green,
  input  logic [rgb2hsl_pkg::CH_W-1:0]   blue,
  input  logic                           done,
  input  logic [rgb2hsl_pkg::HUE_W-1:0]  hue,
  input  logic [rgb2hsl_pkg::FRAC_W-1:0] saturation,
  input  logic [rgb2hsl_pkg::FRAC_W-1:0] lightness,
  output int                             errors,
  output int                             outstanding,
  output int                             checked
);

  localparam int CW = rgb2hsl_pkg::CH_W;
  localparam int HW = rgb2hsl_pkg::HUE_W;
  localparam int FW = rgb2hsl_pkg::FRAC_W;

  localparam int unsigned FRAC_ONE    = 4096;  // 1.0 for saturation and lightness
  localparam int unsigned HUE_SECTOR  = 3840;  // 60 degrees in 1/64 degree units
  localparam int unsigned LUM_SPAN    = 510;   // largest channel sum
  localparam int unsigned TURN        = 32'(rgb2hsl_pkg::HUE_FULL_TURN);

  typedef struct packed {
    logic [HW-1:0] hue;
    logic [FW-1:0] sat;
    logic [FW-1:0] lum;
  } hsl_t;

  hsl_t hsl_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
  end

  // nearest integer, exact halves up
  function automatic int unsigned rounded_quotient(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsl_t hsl_of(logic [CW-1:0] r_in, logic [CW-1:0] g_in,
                                  logic [CW-1:0] b_in);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned hi;
    int unsigned lo;
    int unsigned total;
    int unsigned spread;
    int unsigned den;
    int unsigned units;
    int unsigned hue_val;
    hsl_t        res;
    res = '0;
    r   = 32'(r_in);
    g   = 32'(g_in);
    b   = 32'(b_in);
    hi  = r;
    lo  = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    total   = hi + lo;
    res.lum = FW'(rounded_quotient(FRAC_ONE * total, LUM_SPAN));
    // grey pixel: hue and saturation stay zero
    if (hi != lo) begin
      spread  = hi - lo;
      den     = (total > LUM_SPAN / 2) ? LUM_SPAN - total : total;
      res.sat = FW'(rounded_quotient(FRAC_ONE * spread, den));
      // first channel equal to the max picks the sector
      if (hi == r) begin
        units = (g < b) ? 6 * spread - (b - g) : g - b;
      end else if (hi == g) begin
        units = 2 * spread + b - r;
      end else begin
        units = 4 * spread + r - g;
      end
      hue_val = rounded_quotient(HUE_SECTOR * units, spread);
      if (hue_val >= TURN) hue_val -= TURN;
      res.hue = hue_val[HW-1:0];
    end
    return res;
  endfunction

  task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
    end
  endtask

  always @(posedge clk) begin
    hsl_t want;
    if (!rst) begin
      if (done) begin
        if (hsl_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual hue %0d sat %0d lum %0d",
                   $time, hue, saturation, lightness);
        end else begin
          want = hsl_q.pop_front();
          compare_field("hue", 32'(want.hue), 32'(hue));
          compare_field("saturation", 32'(want.sat), 32'(saturation));
          compare_field("lightness", 32'(want.lum), 32'(lightness));
          checked++;
        end
      end
      if (start && !busy) hsl_q.push_back(hsl_of(red, green, blue));
    end
    outstanding <= hsl_q.size();
  end

endmodule

FILE: sim/rgb_to_hsl_converter_core_test.sv
// ============================================================================
// rgb_to_hsl_converter_core_test
// Drives pixels into the RGB to HSL converter: a directed set of corner
// pixels, then random phases with different sender idle rates. A checker
// beside the core predicts and compares every result beat.
// ============================================================================
module rgb_to_hsl_converter_core_test;

  localparam int CW = rgb2hsl_pkg::CH_W;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           start      = 1'b0;
  logic                           busy;
  logic [CW-1:0]                  red        = '0;
  logic [CW-1:0]                  green      = '0;
  logic [CW-1:0]                  blue       = '0;
  logic                           done;
  logic [rgb2hsl_pkg::HUE_W-1:0]  hue;
  logic [rgb2hsl_pkg::FRAC_W-1:0] saturation;
  logic [rgb2hsl_pkg::FRAC_W-1:0] lightness;

  int errors;
  int outstanding;
  int checked;
  int idle_pct   = 0;   // chance per cycle that the sender holds off
  int pixels_sent = 0;
  int directed_count;

  localparam int PHASE_BEATS = 470;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_to_hsl_converter_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  hsl_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .done        (done),
    .hue         (hue),
    .saturation  (saturation),
    .lightness   (lightness),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Hold one pixel until it is taken, then maybe idle for a while. Idle
  // cycles carry junk on the channels so a stray capture would show up.
  task automatic send_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      red   <= CW'($urandom);
      green <= CW'($urandom);
      blue  <= CW'($urandom);
      @(posedge clk);
    end
  endtask

  // near-black, near-white and mid-scale values hit the rounding and
  // lightness-half boundaries
  function automatic logic [CW-1:0] corner_value();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    int            kind;
    r    = CW'($urandom);
    g    = CW'($urandom);
    b    = CW'($urandom);
    kind = $urandom_range(99);
    if (kind < 10) begin
      // grey
      g = r;
      b = r;
    end else if (kind < 25) begin
      // two channels tied, often for the max
      case ($urandom_range(2))
        0:       g = r;
        1:       b = g;
        default: b = r;
      endcase
    end else if (kind < 40) begin
      if ($urandom_range(1)) r = corner_value();
      if ($urandom_range(1)) g = corner_value();
      if ($urandom_range(1)) b = corner_value();
    end
    send_pixel(r, g, b);
  endtask

  // Stop sending until every result beat has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int phase_idle[4];
    // the first and third phases run without idling; the receiver has no
    // back-pressure
    phase_idle = '{0, 88, 0, 6};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);    // red sector
    send_pixel(8'd0,   8'd255, 8'd0);    // green sector
    send_pixel(8'd0,   8'd0,   8'd255);  // blue sector
    send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie, red wins
    send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie, green wins
    send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie, red wins
    send_pixel(8'd255, 8'd0,   8'd1);    // red max, green below blue: hue close to a full turn
    send_pixel(8'd255, 8'd1,   8'd0);    // just past zero hue
    send_pixel(8'd255, 8'd0,   8'd128);  // sum 255, lower saturation formula
    send_pixel(8'd255, 8'd1,   8'd1);    // sum 256, upper saturation formula
    send_pixel(8'd128, 8'd127, 8'd127);  // lightness at exactly half
    send_pixel(8'd128, 8'd128, 8'd127);  // tie on max at half lightness
    send_pixel(8'd1,   8'd0,   8'd0);    // smallest spread near black
    send_pixel(8'd255, 8'd254, 8'd254);  // smallest spread near white
    send_pixel(8'd85,  8'd170, 8'd255);  // blue max with mixed diffs
    send_pixel(8'd170, 8'd255, 8'd85);   // green max
    send_pixel(8'hAA,  8'h55,  8'hFF);   // alternating bit patterns
    send_pixel(8'h55,  8'hAA,  8'h00);
    directed_count = pixels_sent;
    drain();

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_BEATS) send_random_pixel();
      drain();
    end
    idle_pct = 0;

    repeat (rgb2hsl_pkg::LATENCY + 4) @(posedge clk);

    $display("tb: %0d pixels sent (%0d directed, rest random over four idle phases)",
             pixels_sent, directed_count);
    $display("tb: %0d result beats checked, %0d mismatches", checked, errors);
    if (errors == 0 && outstanding == 0 && checked == pixels_sent) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
src/rgb2hsl_pkg.sv
src/rgb2hsl_front.sv
src/rgb2hsl_div.sv
src/rgb_to_hsl_converter_core.sv
src/rgb2hsl_chk.sv
sim/hsl_result_checker.sv
sim/rgb_to_hsl_converter_core_test.sv
